// ===== sv/step_path_erraticism_macros.svh =====
// Assertion macros shared by the step path erraticism RTL.
// Depends on nothing; included by the modules that check themselves.
`ifndef STEP_PATH_ERRATICISM_MACROS_SVH
`define STEP_PATH_ERRATICISM_MACROS_SVH
`ifndef ASSERT_OFF
`define SPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("step_path_erraticism assertion failed");
`define SPE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("step_path_erraticism assertion failed");
`else
`define SPE_ASSERT(lbl, clk, rst, prop)
`define SPE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/spe_pkg.sv =====
// Types and constants of the step path erraticism block.
// Depends on nothing; used by the top module of the block.
package spe_pkg;

   typedef struct packed {
      logic [62:0] step_time;
      logic [15:0] step_length;
      logic [15:0] step_heading;
   } spe_req_type;

   typedef struct packed {
      logic [62:0] out_time;
      logic [16:0] erraticism;
   } spe_rsp_type;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBORS = 2'd1;

   localparam logic [30:0] THRESHOLD_RESET = 31'd917504;
   localparam logic [5:0]  NEIGHBORS_RESET = 6'd25;

   localparam int CORDIC_ITERS = 24;
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

   // Arctangent of 2^-i in units of 2^-32 of a circle.
   function automatic logic [29:0] atan_units(input logic [4:0] i);
      logic [29:0] a;
      case (i)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/spe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the position history of the block.
module spe_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/step_path_erraticism.sv =====
// Step path erraticism: dead reckoning from pedometer steps. Each transaction
// takes one step, updates the position and returns the timestamp and an
// erraticism in Q1.16. A result skips the history scan when fewer than
// neighbor_count earlier steps exist. Otherwise the step scans neighbor_count
// history entries, and skips the division when the distance reaches the
// threshold. The path is 24 CORDIC iterations, the read, difference, two
// square and accumulate states per history entry on the shared multiplier and
// the history RAM port, 32 square-root steps and a 17-bit quotient division.
// The next step can be taken in the same cycle that the result is presented.
// req_stall is high while a step is in work. A finished result waits in the
// output register while the next step is taken. A result still stalled there
// holds the next one in its last state, and that holds the input.
`include "step_path_erraticism_macros.svh"
module step_path_erraticism import spe_pkg::*; #(
   parameter int MAX_NEIGHBORS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spe_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spe_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]          csr_wdata
);
   localparam int PTR_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CORD, S_TRIG, S_MULX, S_MULY, S_POSY, S_CHECK, S_RD, S_DIFF,
      S_SQX, S_SQY, S_ACC, S_SQRT, S_DIVSET, S_DIV, S_FIN
   } state_type;

   state_type state_ff;
   logic [4:0] it_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [17:0] cs_ff, sn_ff;
   logic [15:0] len_ff;
   logic [62:0] time_ff;
   logic signed [67:0] prod_ff;
   logic signed [39:0] pos_x_ff, pos_y_ff;
   logic [PTR_W-1:0] ptr_ff, slot_ff;
   logic [CNT_W-1:0] steps_ff, k_ff;
   logic [31:0] dx_ff, dy_ff;
   logic [63:0] sqx_ff, best_ff, v_ff, r_ff;
   logic [31:0] dist_ff, rem_ff;
   logic [16:0] num_ff, q_ff, res_ff;
   logic [30:0] thr_ff;
   logic [5:0] nc_ff;
   logic rsp_valid_ff;
   spe_rsp_type rsp_data_ff;

   // The finished step leaves when the output register is free or being read.
   logic fin_go;
   assign fin_go = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   // Shared multiplier.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod;
   always_comb begin
      unique case (state_ff)
         S_MULX: begin mul_a = signed'({18'd0, len_ff}); mul_b = 34'(cs_ff); end
         S_MULY: begin mul_a = signed'({18'd0, len_ff}); mul_b = 34'(sn_ff); end
         S_SQX:  begin mul_a = signed'({2'd0, dx_ff}); mul_b = signed'({2'd0, dx_ff}); end
         default: begin mul_a = signed'({2'd0, dy_ff}); mul_b = signed'({2'd0, dy_ff}); end
      endcase
   end
   assign prod = mul_a * mul_b;

   // CORDIC step and initial quadrant fold.
   logic signed [33:0] xs, ys, at, z0, x0;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign at = signed'({4'd0, atan_units(it_ff)});
   always_comb begin
      z0 = 34'(signed'({req_data.step_heading, 16'd0}));
      x0 = CORDIC_K;
      if (z0 > 34'sd1073741824) begin
         x0 = -CORDIC_K;
         z0 = z0 - 34'sd2147483648;
      end else if (z0 < -34'sd1073741824) begin
         x0 = -CORDIC_K;
         z0 = z0 + 34'sd2147483648;
      end
   end

   // Position increment, rounded to Q.16, and saturation to 40 bits.
   logic signed [67:0] inc;
   logic signed [40:0] sum_in;
   logic signed [39:0] sat_in;
   logic signed [39:0] pos_sel;
   assign inc = (prod_ff + 68'sd128) >>> 8;
   assign pos_sel = (state_ff == S_MULY) ? pos_x_ff : pos_y_ff;
   assign sum_in = 41'(pos_sel) + 41'(inc);
   always_comb begin
      if (sum_in > 41'sd549755813887) sat_in = 40'sh7FFFFFFFFF;
      else if (sum_in < -41'sd549755813888) sat_in = 40'sh8000000000;
      else sat_in = sum_in[39:0];
   end

   // Effective neighbor count.
   logic [8:0] nc_clip;
   logic [CNT_W-1:0] n_eff;
   always_comb begin
      nc_clip = (nc_ff == 6'd0) ? 9'd1 : 9'(nc_ff);
      if (nc_clip > 9'(MAX_NEIGHBORS)) nc_clip = 9'(MAX_NEIGHBORS);
      n_eff = CNT_W'(nc_clip);
   end

   // History RAM.
   logic [79:0] rd_data;
   spe_ram #(.WIDTH(80), .DEPTH(MAX_NEIGHBORS)) u_ring (
      .clock   (clock),
      .wr_en   (fin_go),
      .wr_addr (ptr_ff),
      .wr_data ({pos_x_ff, pos_y_ff}),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   function automatic logic [31:0] abs_lim(input logic signed [39:0] a,
                                            input logic signed [39:0] b);
      logic signed [40:0] d;
      logic [40:0] m;
      d = 41'(a) - 41'(b);
      m = d[40] ? 41'(-d) : 41'(d);
      return (m > 41'd2147483648) ? 32'h80000000 : m[31:0];
   endfunction

   logic [PTR_W-1:0] prev_ptr, prev_slot;
   assign prev_ptr  = (ptr_ff == '0) ? PTR_W'(MAX_NEIGHBORS - 1) : ptr_ff - 1'b1;
   assign prev_slot = (slot_ff == '0) ? PTR_W'(MAX_NEIGHBORS - 1) : slot_ff - 1'b1;

   logic [63:0] sq_sum, sq_bit, sq_trial;
   assign sq_sum   = sqx_ff + 64'(prod_ff);
   assign sq_bit   = 64'd1 << {it_ff, 1'b0};
   assign sq_trial = r_ff + sq_bit;

   logic [30:0] thr_eff;
   logic [47:0] num_full;
   logic [31:0] div_t;
   logic div_ge;
   logic [16:0] q_next;
   assign thr_eff  = (thr_ff == '0) ? 31'd1 : thr_ff;
   assign num_full = {dist_ff, 16'd0} + 48'(thr_eff >> 1);
   assign div_t    = {rem_ff[30:0], num_ff[16]};
   assign div_ge   = (div_t >= 32'(thr_eff));
   assign q_next   = {q_ff[15:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         ptr_ff       <= '0;
         steps_ff     <= '0;
         thr_ff       <= THRESHOLD_RESET;
         nc_ff        <= NEIGHBORS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_wdata;
               CSR_NEIGHBORS: nc_ff  <= csr_wdata[5:0];
               default: ;
            endcase
         end
         rsp_valid_ff <= fin_go || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               time_ff  <= req_data.step_time;
               len_ff   <= req_data.step_length;
               x_ff     <= x0;
               y_ff     <= '0;
               z_ff     <= z0;
               it_ff    <= '0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + at;
               end
               if (it_ff == 5'(CORDIC_ITERS - 1)) state_ff <= S_TRIG;
               it_ff <= it_ff + 1'b1;
            end
            S_TRIG: begin
               cs_ff    <= 18'((x_ff + 34'sd8192) >>> 14);
               sn_ff    <= 18'((y_ff + 34'sd8192) >>> 14);
               state_ff <= S_MULX;
            end
            S_MULX: begin
               prod_ff  <= prod;
               state_ff <= S_MULY;
            end
            S_MULY: begin
               // prod_ff holds length * cos here; the sine product replaces it.
               pos_x_ff <= sat_in;
               prod_ff  <= prod;
               state_ff <= S_POSY;
            end
            S_POSY: begin
               pos_y_ff <= sat_in;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               best_ff <= '0;
               k_ff    <= CNT_W'(1);
               slot_ff <= prev_ptr;
               if (steps_ff >= n_eff) begin
                  state_ff <= S_RD;
               end else begin
                  res_ff   <= '0;
                  state_ff <= S_FIN;
               end
            end
            S_RD:   state_ff <= S_DIFF;
            S_DIFF: begin
               dx_ff    <= abs_lim(pos_x_ff, rd_data[79:40]);
               dy_ff    <= abs_lim(pos_y_ff, rd_data[39:0]);
               state_ff <= S_SQX;
            end
            S_SQX: begin
               prod_ff  <= prod;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sqx_ff   <= 64'(prod_ff);
               prod_ff  <= prod;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (sq_sum > best_ff) best_ff <= sq_sum;
               if (k_ff == n_eff) begin
                  v_ff     <= (sq_sum > best_ff) ? sq_sum : best_ff;
                  r_ff     <= '0;
                  it_ff    <= 5'd31;
                  state_ff <= S_SQRT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  slot_ff  <= prev_slot;
                  state_ff <= S_RD;
               end
            end
            S_SQRT: begin
               if (v_ff >= sq_trial) begin
                  v_ff <= v_ff - sq_trial;
                  r_ff <= (r_ff >> 1) + sq_bit;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               it_ff <= it_ff - 1'b1;
               if (it_ff == 5'd0) state_ff <= S_DIVSET;
            end
            S_DIVSET: begin
               if (32'(r_ff) >= 32'(thr_eff) || r_ff[63:32] != '0) begin
                  res_ff   <= '0;
                  state_ff <= S_FIN;
               end else begin
                  dist_ff  <= r_ff[31:0];
                  state_ff <= S_DIV;
                  it_ff    <= 5'd17;
               end
            end
            S_DIV: begin
               if (it_ff == 5'd17) begin
                  // First cycle only loads the numerator into the divider.
                  rem_ff <= {1'b0, num_full[47:17]};
                  num_ff <= num_full[16:0];
                  q_ff   <= '0;
               end else begin
                  rem_ff <= div_ge ? div_t - 32'(thr_eff) : div_t;
                  q_ff   <= q_next;
                  num_ff <= num_ff << 1;
               end
               if (it_ff == 5'd0) begin
                  res_ff   <= 17'd65536 - q_next;
                  state_ff <= S_FIN;
               end
               it_ff <= it_ff - 1'b1;
            end
            S_FIN: if (fin_go) begin
               rsp_data_ff.out_time   <= time_ff;
               rsp_data_ff.erraticism <= res_ff;
               ptr_ff   <= (ptr_ff == PTR_W'(MAX_NEIGHBORS - 1)) ? '0 : ptr_ff + 1'b1;
               if (steps_ff < CNT_W'(MAX_NEIGHBORS)) steps_ff <= steps_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPE_ASSERT(a_steps_bound, clock, reset, steps_ff <= CNT_W'(MAX_NEIGHBORS))
   `SPE_ASSERT(a_rsp_from_fin, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
   `SPE_ASSERT(a_errat_range, clock, reset,
      rsp_valid_ff |-> rsp_data_ff.erraticism <= 17'd65536)
   `SPE_ASSERT(a_scan_bound, clock, reset,
      (state_ff == S_RD || state_ff == S_ACC) |-> (k_ff >= CNT_W'(1) && k_ff <= n_eff))
endmodule
